// File: rtl/tesc_pkg.sv
// ----------------------------------------------------------------------------
// tesc_pkg
// Kind codes, cfg indices and shared types for the typed element store converter.
// ----------------------------------------------------------------------------
package tesc_pkg;

  typedef enum logic [3:0] {
    KIND_I8  = 4'd0,
    KIND_U8  = 4'd1,
    KIND_U8C = 4'd2,
    KIND_I16 = 4'd3,
    KIND_U16 = 4'd4,
    KIND_I32 = 4'd5,
    KIND_U32 = 4'd6,
    KIND_F32 = 4'd7,
    KIND_F64 = 4'd8
  } kind_e;

  localparam logic CFG_VIEW_LENGTH = 1'b0;
  localparam logic CFG_VIEW_OFFSET = 1'b1;

  typedef struct packed {
    logic        ok;
    logic [3:0]  bytes;
    logic [23:0] addr;
    logic [63:0] bits;
  } result_t;

endpackage

// File: rtl/typed_element_store_convert.sv
// ----------------------------------------------------------------------------
// typed_element_store_convert
// Range check, element conversion and byte addressing for typed-view stores.
// ----------------------------------------------------------------------------
// channel  direction  fields
// in       input      kind, index, value_bits
// out      output     accepted, byte_address, element_bytes, element_bits
// cfg      input      view_length (0), view_byte_offset (1)
//
// One word per cycle while the result side is not stalled; an accepted word
// goes through the input register, then the result register, to the ports.
// Input ready depends on the result register's advance; reset empties both.
// A stalled result holds the pipe; no words are dropped.
module typed_element_store_convert #(
  parameter longint unsigned MAX_ELEMENTS = 1048576
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [20:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  kind_i,
  input  logic [31:0] index_i,
  input  logic [63:0] value_bits_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        accepted_o,
  output logic [23:0] byte_address_o,
  output logic [3:0]  element_bytes_o,
  output logic [63:0] element_bits_o
);
  import tesc_pkg::*;

  logic [20:0] len_q;
  logic [19:0] ofs_q;
  logic        iv_q, ov_q, adv;
  logic [3:0]  kind_q;
  logic [31:0] idx_q;
  logic [63:0] val_q;
  result_t     res_d, res_q;
  logic [63:0] elem;
  logic [32:0] limit;

  assign adv        = !ov_q || out_ready_i;
  assign in_ready_o = !iv_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      ofs_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_VIEW_LENGTH) len_q <= cfg_data_i;
      else ofs_q <= cfg_data_i[19:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (in_ready_o) iv_q <= in_valid_i;
      if (adv) ov_q <= iv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      kind_q <= kind_i;
      idx_q  <= index_i;
      val_q  <= value_bits_i;
    end
    if (adv && iv_q) res_q <= res_d;
  end

  tesc_convert u_conv (
    .kind_i      (kind_q),
    .value_bits_i(val_q),
    .elem_o      (elem)
  );

  always_comb begin
    limit = (33'(len_q) < 33'(MAX_ELEMENTS)) ? 33'(len_q) : 33'(MAX_ELEMENTS);
    case (kind_q)
      KIND_I16, KIND_U16:           res_d.bytes = 4'd2;
      KIND_I32, KIND_U32, KIND_F32: res_d.bytes = 4'd4;
      KIND_F64:                     res_d.bytes = 4'd8;
      default:                      res_d.bytes = 4'd1;
    endcase
    res_d.ok = (kind_q <= KIND_F64) && (33'(idx_q) < limit);
    res_d.addr = res_d.ok ? 24'(24'(ofs_q) + 24'(idx_q[23:0] * 24'(res_d.bytes))) : 24'd0;
    res_d.bits = res_d.ok ? elem : 64'd0;
  end

  assign out_valid_o     = ov_q;
  assign accepted_o      = res_q.ok;
  assign byte_address_o  = res_q.addr;
  assign element_bytes_o = res_q.bytes;
  assign element_bits_o  = res_q.bits;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !out_ready_i |=> ov_q && $stable(res_q))
    else $error("result changed while stalled");
  a_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> res_q.bytes == 4'd1 || res_q.bytes == 4'd2 || res_q.bytes == 4'd4
             || res_q.bytes == 4'd8)
    else $error("bad element size");
  a_rej: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !res_q.ok |-> res_q.bits == 64'd0 && res_q.addr == 24'd0)
    else $error("rejected store carries data");

endmodule

// File: rtl/tesc_convert.sv
// ----------------------------------------------------------------------------
// tesc_convert
// Converts one binary64 value into the requested element kind.
// ----------------------------------------------------------------------------
module tesc_convert (
  input  logic [3:0]  kind_i,
  input  logic [63:0] value_bits_i,
  output logic [63:0] elem_o
);
  import tesc_pkg::*;

  logic        sgn;
  logic [10:0] be;
  logic [52:0] man;
  logic        is_nan;
  logic [40:0] mag;
  logic [40:0] mag_n;
  logic [8:0]  clamp_r;
  logic [31:0] f32;
  logic [63:0] elem;
  logic [40:0] lim_pos;
  logic [40:0] lim_neg;
  logic [40:0] lim_u;
  logic [63:0] sat_s;
  logic [63:0] sat_u;
  logic [63:0] mask;
  logic [105:0] shf;
  logic [35:0] r32;
  logic [54:0] sub_q;
  logic        sub_g;
  logic        sub_st;
  logic [12:0] fe;
  logic [35:0] ofs;
  logic [6:0]  sh;

  assign sgn    = value_bits_i[63];
  assign be     = value_bits_i[62:52];
  assign man    = {1'b1, value_bits_i[51:0]};
  assign is_nan = (be == 11'h7FF) && (value_bits_i[51:0] != 52'd0);

  always_comb begin
    if (be < 11'd1023) mag = '0;
    else if (be >= 11'd1063) mag = 41'h100_0000_0000;
    else mag = 41'(man >> (7'd52 - 7'(be - 11'd1023)));
  end

  // clamped byte: (m + 2^(51-e)) >> (52-e), e in -1..7
  always_comb begin
    logic [6:0]  cs;
    logic [53:0] sum;
    cs  = 7'(7'd52 - 7'(be - 11'd1022) + 7'd1);
    sum = {1'b0, man} + (54'd1 << (cs - 7'd1));
    clamp_r = 9'(sum >> cs);
  end

  // float32 with ties to even
  always_comb begin
    logic [52:0] rem;
    logic [52:0] half;
    fe  = 13'(be) - 13'd896;
    sub_q = '0; sub_g = 1'b0; sub_st = 1'b0; r32 = '0; ofs = '0; sh = '0;
    rem = '0; half = '0; shf = '0;
    if (be == 11'h7FF) f32 = {sgn, 31'h7F80_0000};
    else if (be == 11'd0) f32 = {sgn, 31'd0};
    else if (!fe[12] && fe != 13'd0) begin
      sub_q = 55'(man >> 29);
      rem = man & 53'h1FFF_FFFF;
      half = 53'h1000_0000;
      if (rem > half || (rem == half && sub_q[0])) sub_q = sub_q + 55'd1;
      ofs = 36'(fe - 13'd1) << 23;
      r32 = ofs + 36'(sub_q);
      if (r32 >= 36'h7F80_0000) r32 = 36'h7F80_0000;
      f32 = {sgn, r32[30:0]};
    end else if (13'd30 - fe > 13'd54) f32 = {sgn, 31'd0};
    else begin
      sh = 7'(13'd30 - fe);
      shf = {man, 53'd0} >> sh;
      sub_q = 55'(shf[105:53]);
      rem = shf[52:0];
      half = 53'h10_0000_0000_0000;
      sub_g = rem > half;
      sub_st = rem == half;
      if (sub_g || (sub_st && sub_q[0])) sub_q = sub_q + 55'd1;
      f32 = {sgn, 31'(sub_q)};
    end
  end

  always_comb begin
    case (kind_i)
      KIND_I8, KIND_U8:   begin lim_pos = 41'd127; lim_u = 41'd255; mask = 64'hFF; end
      KIND_I16, KIND_U16: begin lim_pos = 41'd32767; lim_u = 41'd65535; mask = 64'hFFFF; end
      default: begin lim_pos = 41'h7FFF_FFFF; lim_u = 41'hFFFF_FFFF; mask = 64'hFFFF_FFFF; end
    endcase
    lim_neg = lim_pos + 41'd1;
    mag_n   = (mag > lim_neg) ? lim_neg : mag;
    sat_s   = sgn ? ((64'd0 - 64'(mag_n)) & mask) : 64'((mag > lim_pos) ? lim_pos : mag);
    sat_u   = sgn ? 64'd0 : 64'((mag > lim_u) ? lim_u : mag);
    case (kind_i)
      KIND_I8, KIND_I16, KIND_I32: elem = sat_s;
      KIND_U8, KIND_U16, KIND_U32: elem = sat_u;
      KIND_U8C: begin
        if (sgn || be < 11'd1022) elem = '0;
        else if (be >= 11'd1031 || clamp_r > 9'd255) elem = 64'd255;
        else elem = 64'(clamp_r);
      end
      KIND_F32: elem = {32'd0, f32};
      KIND_F64: elem = value_bits_i;
      default:  elem = '0;
    endcase
  end

  assign elem_o = is_nan ? 64'd0 : elem;

endmodule
